// ----- hdl/assert_macros.svh -----
// ------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker top level; they compile
// away when SYNTHESIS is defined.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, sampled on the rising clock, disabled while in reset.
`define LRPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lrpc assertion failed");
// Same-cycle implication from a condition to a consequence.
`define LRPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrpc implication failed");
// Next-cycle implication from a condition to a consequence.
`define LRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrpc next-cycle implication failed");
`else
`define LRPC_ASSERT(lbl, clk, rst_n, prop)
`define LRPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LRPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/lrpc_pkg.sv -----
// ------------------------------------------------------------------------
// LFSR read pattern checker package
// Widths, register indexes, payload types and the LFSR step function.
// ------------------------------------------------------------------------
package lrpc_pkg;

  // Lane count limits and default.
  localparam int LANES_DEF = 8;
  localparam int MAX_LANES = 8;

  // Field widths.
  localparam int LFSR_W  = 8;
  localparam int WORD_W  = 16;
  localparam int PHASE_W = 3;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Feedback taps: old bit 0 goes to bit 7 and into bits 5, 4 and 3.
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 8'hB8;

  // Phase codes with a special meaning.
  localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd7;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_SEED_ZERO   = 2'd0;
  localparam logic [1:0] REG_SEED_ONE    = 2'd1;
  localparam logic [1:0] REG_INVERT_MASK = 2'd2;
  localparam logic [1:0] REG_SELECT_MASK = 2'd3;

  // Input word.
  typedef struct packed {
    logic [WORD_W-1:0]  phase_word;
    logic [PHASE_W-1:0] phase_index;
  } lrpc_in_t;

  // Result word.
  typedef struct packed {
    logic                 pattern_ok;
    logic [MAX_LANES-1:0] failing_lanes;
  } lrpc_out_t;

  // Per-word control broadcast to the lanes and the merge stage.
  typedef struct packed {
    logic fire;
    logic reload;
    logic finish;
  } lrpc_ctrl_t;

  // One LFSR step.
  function automatic logic [LFSR_W-1:0] lfsr_advance(logic [LFSR_W-1:0] x);
    logic [LFSR_W-1:0] nx;
    nx = x >> 1;
    if (x[0]) begin
      nx = nx ^ LFSR_TAPS;
    end
    return nx;
  endfunction

endpackage

// ----- hdl/lrpc_lane.sv -----
// ------------------------------------------------------------------------
// Checker lane
// Holds one lane's LFSR, compares both beats of a word and steps twice.
// ------------------------------------------------------------------------
module lrpc_lane
  import lrpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrpc_ctrl_t        ctrl_i,
  input  logic [1:0]        beats_i,
  input  logic [LFSR_W-1:0] seed_zero_i,
  input  logic [LFSR_W-1:0] seed_one_i,
  input  logic              select_i,
  input  logic              invert_i,
  output logic              mismatch_o
);

  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [LFSR_W-1:0] start, mid;
  logic [1:0]        bits;

  // Starting value is the selected seed at phase zero, else the running state.
  always_comb begin
    start      = ctrl_i.reload ? (select_i ? seed_one_i : seed_zero_i) : lfsr_q;
    mid        = lfsr_advance(start);
    bits       = beats_i ^ {2{invert_i}};
    mismatch_o = (bits[0] != start[0]) | (bits[1] != mid[0]);
    lfsr_d     = ctrl_i.fire ? lfsr_advance(mid) : lfsr_q;
  end

  // LFSR state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= '0;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

endmodule

// ----- hdl/lrpc_merge.sv -----
// ------------------------------------------------------------------------
// Lane merge stage
// Accumulates the lanes' mismatch flags and registers the result word.
// ------------------------------------------------------------------------
module lrpc_merge
  import lrpc_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lrpc_ctrl_t       ctrl_i,
  input  logic [LANES-1:0] lane_miss_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lrpc_out_t        out_word_o
);

  logic [LANES-1:0]     record_q, record_d;
  logic                 valid_q, valid_d;
  lrpc_out_t            word_q, word_d;
  logic [MAX_LANES-1:0] failing;

  // Mismatch record is cleared by phase zero and updated by every word.
  always_comb begin
    record_d = record_q;
    if (ctrl_i.fire) begin
      record_d = (ctrl_i.reload ? '0 : record_q) | lane_miss_i;
    end
    failing             = '0;
    failing[LANES-1:0]  = record_d;
    word_d.pattern_ok    = (record_d == '0);
    word_d.failing_lanes = failing;
  end

  // Output register: loaded on a finishing word, emptied when taken.
  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (ctrl_i.fire && ctrl_i.finish) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      record_q <= record_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire && ctrl_i.finish) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ----- hdl/lfsr_read_pattern_checker_top.sv -----
// ------------------------------------------------------------------------
// LFSR read pattern checker
// Checks eight phase words of read-training data against per-lane LFSRs.
// ------------------------------------------------------------------------
// Throughput: one phase word per cycle unless a full result register stalls
// the input; each lane does both LFSR steps per word in its own combinational
// next-state logic; the result is registered when the phase-seven word is taken.
// Reset: registers, lane LFSRs, the mismatch record and output valid go to 0.
`include "assert_macros.svh"

module lfsr_read_pattern_checker_top
  import lrpc_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrpc_in_t          in_word_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lrpc_out_t         out_word_o
);

  logic [LFSR_W-1:0] seed_zero_q, seed_one_q;
  logic [LFSR_W-1:0] invert_q, select_q;
  logic              cfg_write;
  logic [1:0]        reg_index;
  lrpc_ctrl_t        ctrl;
  logic [LANES-1:0]  lane_miss;

  // Register file write and read.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_zero_q <= '0;
      seed_one_q  <= '0;
      invert_q    <= '0;
      select_q    <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_SEED_ZERO:   seed_zero_q <= pwdata[LFSR_W-1:0];
        REG_SEED_ONE:    seed_one_q  <= pwdata[LFSR_W-1:0];
        REG_INVERT_MASK: invert_q    <= pwdata[LFSR_W-1:0];
        REG_SELECT_MASK: select_q    <= pwdata[LFSR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_index)
      REG_SEED_ZERO:   prdata[LFSR_W-1:0] = seed_zero_q;
      REG_SEED_ONE:    prdata[LFSR_W-1:0] = seed_one_q;
      REG_INVERT_MASK: prdata[LFSR_W-1:0] = invert_q;
      REG_SELECT_MASK: prdata[LFSR_W-1:0] = select_q;
      default:         prdata = '0;
    endcase
  end

  // A word is taken whenever the result register is empty or being drained.
  assign in_ready_o  = !out_valid_o || out_ready_i;
  assign ctrl.fire   = in_valid_i && in_ready_o;
  assign ctrl.reload = (in_word_i.phase_index == PHASE_FIRST);
  assign ctrl.finish = (in_word_i.phase_index == PHASE_LAST);

  // One checker lane per data lane.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lrpc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .beats_i     ({in_word_i.phase_word[g + LANES], in_word_i.phase_word[g]}),
      .seed_zero_i (seed_zero_q),
      .seed_one_i  (seed_one_q),
      .select_i    (select_q[g]),
      .invert_i    (invert_q[g]),
      .mismatch_o  (lane_miss[g])
    );
  end

  // Merge the lane flags into the result word.
  lrpc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .lane_miss_i (lane_miss),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // Checks on the block's own logic.
  `LRPC_ASSERT_IMPL(a_stall_only_on_full, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  `LRPC_ASSERT_NEXT(a_last_phase_emits, clk_i, rst_ni, ctrl.fire && ctrl.finish, out_valid_o)
  `LRPC_ASSERT_IMPL(a_ok_matches_lanes, clk_i, rst_ni, out_valid_o,
                    out_word_o.pattern_ok == (out_word_o.failing_lanes == '0))
  `LRPC_ASSERT_IMPL(a_no_phantom_lanes, clk_i, rst_ni, out_valid_o,
                    (out_word_o.failing_lanes >> LANES) == '0)

endmodule
